>>> design/vfa_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, opcodes and saturation helper for the vector ALU.
// No dependencies; every other design file imports this package.
package vfa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W     = 32;
	localparam int PW    = 2 * W;
	localparam int SUMW  = PW + 2;
	localparam int ROOTW = SUMW / 2;
	localparam int REMW  = ROOTW + 2;
	localparam int QW    = FRAC_BITS + 1;
	localparam int DVW   = W + FRAC_BITS;
	localparam int DCW   = ROOTW + QW;
	localparam int LAT   = 4 + ROOTW + QW + 1;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_SCALE = 3'd2,
		OP_EQ    = 3'd3,
		OP_DOT   = 3'd4,
		OP_MAG   = 3'd5,
		OP_NORM  = 3'd6
	} opcode_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic         hit;
		logic [W-1:0] val;
	} sat_t;

	typedef struct packed {
		opcode_t           op;
		logic [3:0][W-1:0] r;
		logic [W-1:0]      sc;
		logic              eq;
		logic [1:0]        st;
		logic [3:0]        neg;
		logic [3:0][W-1:0] mag;
	} item_t;

	function automatic sat_t sat_w(input logic signed [SUMW-1:0] v);
		sat_t s;
		s.hit = !((&v[SUMW-1:W-1]) || !(|v[SUMW-1:W-1]));
		s.val = s.hit ? (v[SUMW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
			: v[W-1:0];
		return s;
	endfunction

endpackage

>>> design/vfa_lane.sv
`timescale 1ns / 1ps
// One component lane: shared multiplier, add/sub, scale, compare and abs value.
// Depends on vfa_pkg.
module vfa_lane import vfa_pkg::*; (
	input  logic                  clk,
	input  opcode_t               op,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	input  logic signed [W-1:0]   f,
	output logic signed [PW-1:0]  prod_s2,
	output sat_t                  addsub_s3,
	output sat_t                  scale_s3,
	output logic                  eq_s3,
	output logic                  neg_s3,
	output logic [W-1:0]          mag_s3
);

	logic signed [W-1:0]    mb;
	logic signed [W:0]      as_c;
	logic [W-1:0]           abs_c;
	sat_t                   addsub_s2;
	logic                   eq_s2;
	logic                   neg_s2;
	logic [W-1:0]           mag_s2;
	logic signed [SUMW-1:0] pext;

	always_comb begin
		case (op) inside
			OP_SCALE:        mb = f;
			OP_MAG, OP_NORM: mb = a;
			default:         mb = b;
		endcase
	end

	assign as_c  = (op == OP_SUB) ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
	assign abs_c = a[W-1] ? (~a + 1'b1) : a;
	assign pext  = SUMW'(prod_s2);

	always_ff @(posedge clk) begin
		prod_s2   <= a * mb;
		addsub_s2 <= sat_w({{(SUMW-W-1){as_c[W]}}, as_c});
		eq_s2     <= (a == b);
		neg_s2    <= a[W-1];
		mag_s2    <= abs_c;
	end

	always_ff @(posedge clk) begin
		addsub_s3 <= addsub_s2;
		scale_s3  <= sat_w(pext >>> FRAC_BITS);
		eq_s3     <= eq_s2;
		neg_s3    <= neg_s2;
		mag_s3    <= mag_s2;
	end

endmodule

>>> design/vfa_merge.sv
`timescale 1ns / 1ps
// Registered adder tree that merges the four lane products into one sum.
// Depends on vfa_pkg.
module vfa_merge import vfa_pkg::*; (
	input  logic                   clk,
	input  logic signed [PW-1:0]   prod [4],
	output logic signed [SUMW-1:0] sum_s4
);

	logic signed [PW:0] pair_s3 [2];

	always_ff @(posedge clk) begin
		pair_s3[0] <= (PW+1)'(prod[0]) + (PW+1)'(prod[1]);
		pair_s3[1] <= (PW+1)'(prod[2]) + (PW+1)'(prod[3]);
		sum_s4     <= SUMW'(pair_s3[0]) + SUMW'(pair_s3[1]);
	end

endmodule

>>> design/vfa_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, request carried along.
// Depends on vfa_pkg.
module vfa_sqrt import vfa_pkg::*; (
	input  logic             clk,
	input  logic [SUMW-1:0]  rad,
	input  item_t            item,
	output logic [ROOTW-1:0] root,
	output item_t            item_o
);

	logic [SUMW-1:0]  rad_q  [ROOTW];
	logic [REMW-1:0]  rem_q  [ROOTW];
	logic [ROOTW-1:0] root_q [ROOTW];
	item_t            item_q [ROOTW];

	for (genvar k = 0; k < ROOTW; k++) begin : g_stage
		logic [SUMW-1:0]  rad_in;
		logic [REMW-1:0]  rem_in;
		logic [ROOTW-1:0] root_in;
		item_t            it_in;
		logic [REMW-1:0]  cur;
		logic [REMW-1:0]  trial;

		if (k == 0) begin : g_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign it_in   = item;
		end else begin : g_next
			assign rad_in  = rad_q[k-1];
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign it_in   = item_q[k-1];
		end

		assign cur   = {rem_in[REMW-3:0], rad_in[SUMW-1:SUMW-2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk) begin
			rad_q[k]  <= rad_in << 2;
			item_q[k] <= it_in;
			if (cur >= trial) begin
				rem_q[k]  <= cur - trial;
				root_q[k] <= {root_in[ROOTW-2:0], 1'b1};
			end else begin
				rem_q[k]  <= cur;
				root_q[k] <= {root_in[ROOTW-2:0], 1'b0};
			end
		end
	end

	assign root   = root_q[ROOTW-1];
	assign item_o = item_q[ROOTW-1];

endmodule

>>> design/vfa_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for one component, one quotient bit per stage.
// Depends on vfa_pkg.
module vfa_div import vfa_pkg::*; (
	input  logic             clk,
	input  logic [W-1:0]     mag,
	input  logic [ROOTW-1:0] dsr,
	output logic [QW-1:0]    quo
);

	logic [DVW-1:0]   rem_q [QW];
	logic [ROOTW-1:0] d_q   [QW];
	logic [QW-1:0]    q_q   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DVW-1:0]   rem_in;
		logic [ROOTW-1:0] d_in;
		logic [QW-1:0]    q_in;
		logic [DCW-1:0]   sh;

		if (k == 0) begin : g_first
			assign rem_in = {mag, {FRAC_BITS{1'b0}}};
			assign d_in   = dsr;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign d_in   = d_q[k-1];
			assign q_in   = q_q[k-1];
		end

		assign sh = DCW'(d_in) << (QW - 1 - k);

		always_ff @(posedge clk) begin
			d_q[k] <= d_in;
			if (DCW'(rem_in) >= sh) begin
				rem_q[k] <= rem_in - sh[DVW-1:0];
				q_q[k]   <= {q_in[QW-2:0], 1'b1};
			end else begin
				rem_q[k] <= rem_in;
				q_q[k]   <= {q_in[QW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q[QW-1];

endmodule

>>> design/vec4_fixed_point_alu.sv
`timescale 1ns / 1ps
// Top level of the four-component Q16.16 vector ALU.
// Depends on vfa_pkg, vfa_lane, vfa_merge, vfa_sqrt and vfa_div.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  request   | start / busy         | opcode, a_x..a_w, b_x..b_w, factor
//  result    | done (one-cycle)     | r_x..r_w, scalar, is_equal, status
//
// One request per cycle; every opcode takes the same path through the input
// registers, the lane and adder tree registers, 33 square root stages, 17
// divider stages and the output register. busy is never raised.
// Reset clears only the result strobe pipeline; the receiver cannot stall.
module vec4_fixed_point_alu import vfa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          opcode,
	input  logic signed [W-1:0] a_x,
	input  logic signed [W-1:0] a_y,
	input  logic signed [W-1:0] a_z,
	input  logic signed [W-1:0] a_w,
	input  logic signed [W-1:0] b_x,
	input  logic signed [W-1:0] b_y,
	input  logic signed [W-1:0] b_z,
	input  logic signed [W-1:0] b_w,
	input  logic signed [W-1:0] factor,
	output logic                done,
	output logic signed [W-1:0] r_x,
	output logic signed [W-1:0] r_y,
	output logic signed [W-1:0] r_z,
	output logic signed [W-1:0] r_w,
	output logic signed [W-1:0] scalar,
	output logic                is_equal,
	output logic [1:0]          status
);

	logic [LAT-1:0]         vld_q;
	opcode_t                op_s1, op_s2, op_s3, op_s4;
	logic signed [W-1:0]    a_s1 [4];
	logic signed [W-1:0]    b_s1 [4];
	logic signed [W-1:0]    f_s1;
	logic signed [PW-1:0]   prod_s2 [4];
	sat_t                   addsub_s3 [4];
	sat_t                   scale_s3 [4];
	logic [3:0]             eq_s3, neg_s3;
	logic [W-1:0]           mag_s3 [4];
	sat_t                   addsub_s4 [4];
	sat_t                   scale_s4 [4];
	logic [3:0]             eq_s4, neg_s4;
	logic [W-1:0]           mag_s4 [4];
	logic signed [SUMW-1:0] sum_s4;
	item_t                  it_s4;
	logic [ROOTW-1:0]       root;
	item_t                  sq_item;
	item_t                  it_rt;
	sat_t                   mag_sat;
	item_t                  dly_q [QW];
	logic [QW-1:0]          quo [4];
	item_t                  it_fin;
	logic [3:0][W-1:0]      r_c;
	logic [W-1:0]           r_q [4];
	logic [W-1:0]           sc_q;
	logic                   eq_q;
	logic [1:0]             st_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	always_ff @(posedge clk) begin
		op_s1   <= opcode_t'(opcode);
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		a_s1[3] <= a_w;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
		b_s1[3] <= b_w;
		f_s1    <= factor;
		op_s2   <= op_s1;
		op_s3   <= op_s2;
		op_s4   <= op_s3;
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		vfa_lane u_lane (
			.clk       (clk),
			.op        (op_s1),
			.a         (a_s1[i]),
			.b         (b_s1[i]),
			.f         (f_s1),
			.prod_s2   (prod_s2[i]),
			.addsub_s3 (addsub_s3[i]),
			.scale_s3  (scale_s3[i]),
			.eq_s3     (eq_s3[i]),
			.neg_s3    (neg_s3[i]),
			.mag_s3    (mag_s3[i])
		);

		always_ff @(posedge clk) begin
			addsub_s4[i] <= addsub_s3[i];
			scale_s4[i]  <= scale_s3[i];
			mag_s4[i]    <= mag_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		eq_s4  <= eq_s3;
		neg_s4 <= neg_s3;
	end

	vfa_merge u_merge (
		.clk    (clk),
		.prod   (prod_s2),
		.sum_s4 (sum_s4)
	);

	always_comb begin
		sat_t dot;
		dot       = sat_w(sum_s4 >>> FRAC_BITS);
		it_s4     = '0;
		it_s4.op  = op_s4;
		it_s4.neg = neg_s4;
		for (int i = 0; i < 4; i++) begin
			it_s4.mag[i] = mag_s4[i];
		end
		case (op_s4) inside
			OP_ADD, OP_SUB: begin
				for (int i = 0; i < 4; i++) begin
					it_s4.r[i] = addsub_s4[i].val;
				end
				it_s4.st = (addsub_s4[0].hit | addsub_s4[1].hit | addsub_s4[2].hit
					| addsub_s4[3].hit) ? ST_SAT : ST_OK;
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					it_s4.r[i] = scale_s4[i].val;
				end
				it_s4.st = (scale_s4[0].hit | scale_s4[1].hit | scale_s4[2].hit
					| scale_s4[3].hit) ? ST_SAT : ST_OK;
			end
			OP_EQ: begin
				it_s4.eq = &eq_s4;
			end
			OP_DOT: begin
				it_s4.sc = dot.val;
				it_s4.st = dot.hit ? ST_SAT : ST_OK;
			end
			default: begin
			end
		endcase
	end

	vfa_sqrt u_sqrt (
		.clk    (clk),
		.rad    (sum_s4),
		.item   (it_s4),
		.root   (root),
		.item_o (sq_item)
	);

	assign mag_sat = sat_w({{(SUMW-ROOTW){1'b0}}, root});

	always_comb begin
		it_rt = sq_item;
		if (sq_item.op == OP_MAG) begin
			it_rt.sc = mag_sat.val;
			it_rt.st = mag_sat.hit ? ST_SAT : ST_OK;
		end else if (sq_item.op == OP_NORM && root == '0) begin
			it_rt.st = ST_ZERO;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		vfa_div u_div (
			.clk (clk),
			.mag (sq_item.mag[i]),
			.dsr (root),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		dly_q[0] <= it_rt;
		for (int k = 1; k < QW; k++) begin
			dly_q[k] <= dly_q[k-1];
		end
	end

	assign it_fin = dly_q[QW-1];

	always_comb begin
		r_c = it_fin.r;
		if (it_fin.op == OP_NORM && it_fin.st != ST_ZERO) begin
			for (int i = 0; i < 4; i++) begin
				r_c[i] = it_fin.neg[i] ? (~W'(quo[i]) + 1'b1) : W'(quo[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			r_q[i] <= r_c[i];
		end
		sc_q <= it_fin.sc;
		eq_q <= it_fin.eq;
		st_q <= it_fin.st;
	end

	assign r_x      = r_q[0];
	assign r_y      = r_q[1];
	assign r_z      = r_q[2];
	assign r_w      = r_q[3];
	assign scalar   = sc_q;
	assign is_equal = eq_q;
	assign status   = st_q;

endmodule

>>> design/vfa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the vector ALU and the bind that attaches them.
// Depends on vfa_pkg and vec4_fixed_point_alu.
module vfa_checker import vfa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic signed [W-1:0] r_x,
	input logic signed [W-1:0] scalar,
	input logic                is_equal,
	input logic [1:0]          status
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result strobe missing after request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_SAT || status == ST_ZERO))
		else $error("status code out of range");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ZERO |-> r_x == '0 && scalar == '0 && !is_equal)
		else $error("zero vector result not cleared");

	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_equal |-> status == ST_OK && scalar == '0)
		else $error("compare result carries other fields");

endmodule

bind vec4_fixed_point_alu vfa_checker u_vfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.r_x      (r_x),
	.scalar   (scalar),
	.is_equal (is_equal),
	.status   (status)
);
